### rtl/gmdfs_pkg.sv
// Shared types and constants of the grid maze path search block.
package gmdfs_pkg;

   localparam int GRID_SIDE = 8;
   localparam int CELLS     = GRID_SIDE * GRID_SIDE;
   localparam int COORD_W   = 3;
   localparam int CELL_W    = $clog2(CELLS);
   localparam int DEPTH_W   = CELL_W + 1;
   localparam int DIR_W     = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 64;
   localparam int LENGTH_W  = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_WALL_MAP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_ROW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_COL = 2'd2;

   localparam logic [COORD_W-1:0] GOAL_ROW_RESET = 3'd5;
   localparam logic [COORD_W-1:0] GOAL_COL_RESET = 3'd3;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [CELL_W-1:0]  cell_type;
   typedef logic [DEPTH_W-1:0] depth_type;
   typedef logic [DIR_W-1:0]   dir_type;
   typedef logic [CELLS-1:0]   grid_map_type;

   typedef struct packed {
      dir_type  dir;
      cell_type cell_idx;
   } stack_entry_type;

   function automatic cell_type cell_of(coord_type row, coord_type col);
      return CELL_W'(int'(row) * GRID_SIDE + int'(col));
   endfunction

endpackage

### rtl/gmdfs_if.sv
// Valid/ready channel interfaces for start words and result words.
interface gmdfs_req_if;
   import gmdfs_pkg::*;
   logic      valid;
   logic      ready;
   coord_type start_row;
   coord_type start_col;

   modport source (output valid, output start_row, output start_col, input ready);
   modport sink (input valid, input start_row, input start_col, output ready);
endinterface

interface gmdfs_rsp_if;
   import gmdfs_pkg::*;
   logic                valid;
   logic                ready;
   logic                found;
   grid_map_type        path_map;
   logic [LENGTH_W-1:0] path_length;

   modport source (output valid, output found, output path_map, output path_length,
                   input ready);
   modport sink (input valid, input found, input path_map, input path_length,
                 output ready);
endinterface

### rtl/gmdfs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module gmdfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/grid_maze_dfs_path_search_top.sv
// Top level of the grid maze path search block: sequencer, path state and result register.
//
// The block searches an 8 x 8 grid for a path from a start cell to a goal cell
// by backtracking depth-first search, trying neighbors down, right, up, left.
// The req channel carries one start word (start_row, start_col). The rsp channel
// returns one result word per start word: found, path_map and path_length.
// The csr port writes the wall map (index 0), the goal row (1) and the goal
// column (2); it must be written by the user only while the block is idle; the
// block itself does not enforce this. One stack step is done per cycle: a neighbor
// try, a push, or a pop. A pop also passes through the ST_POP state, which reads
// the entry below from the stack RAM. The next start word is taken only after the
// result is in the output register.
// The result register holds its word while rsp is stalled; a finished search
// waits for it to drain before the block is ready again.
// Reset is synchronous and active high; it sets the wall map to zero, the goal
// to row 5, column 3, and empties the sequencer and the output register.
module grid_maze_dfs_path_search_top (
   input  logic                             clock,
   input  logic                             reset,
   gmdfs_req_if.sink                        req_ch,
   gmdfs_rsp_if.source                      rsp_ch,
   input  logic                             csr_we,
   input  logic [gmdfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gmdfs_pkg::CSR_W-1:0]      csr_wdata
);
   import gmdfs_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_STEP  = 3'd2;
   localparam logic [2:0] ST_POP   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam dir_type DIR_DOWN  = 3'd0;
   localparam dir_type DIR_RIGHT = 3'd1;
   localparam dir_type DIR_UP    = 3'd2;
   localparam dir_type DIR_LEFT  = 3'd3;
   localparam dir_type DIR_SPENT = 3'd4;

   localparam coord_type EDGE_LAST = COORD_W'(GRID_SIDE - 1);
   localparam int SLOT_W = $clog2(CELLS);

   logic [2:0]          state_ff, state_in;
   grid_map_type        wall_map_ff;
   coord_type           goal_row_ff, goal_col_ff;
   coord_type           start_row_ff, start_row_in;
   coord_type           start_col_ff, start_col_in;
   grid_map_type        on_path_ff, on_path_in;
   grid_map_type        dead_ff, dead_in;
   depth_type           depth_ff, depth_in;
   cell_type            top_cell_ff, top_cell_in;
   dir_type             top_dir_ff, top_dir_in;
   logic                found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   grid_map_type        rsp_path_ff, rsp_path_in;
   logic [LENGTH_W-1:0] rsp_length_ff, rsp_length_in;

   coord_type           cur_row, cur_col, nb_row, nb_col;
   logic                nb_inside, nb_goal, nb_open;
   cell_type            nb_cell, start_cell, goal_cell;
   grid_map_type        blocked;
   stack_entry_type     push_entry, pop_entry;
   logic                ram_we, ram_re;
   logic [SLOT_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [$bits(stack_entry_type)-1:0] ram_rd_data;

   gmdfs_ram #(
      .WIDTH ($bits(stack_entry_type)),
      .DEPTH (CELLS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (push_entry),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign pop_entry   = stack_entry_type'(ram_rd_data);
   assign ram_wr_addr = SLOT_W'(depth_ff - depth_type'(1));
   assign ram_rd_addr = SLOT_W'(depth_ff - depth_type'(2));
   assign push_entry  = '{dir: top_dir_ff + dir_type'(1), cell_idx: top_cell_ff};

   assign cur_row    = COORD_W'(top_cell_ff / GRID_SIDE);
   assign cur_col    = COORD_W'(top_cell_ff % GRID_SIDE);
   assign start_cell = cell_of(start_row_ff, start_col_ff);
   assign goal_cell  = cell_of(goal_row_ff, goal_col_ff);
   assign blocked    = wall_map_ff | on_path_ff | dead_ff;

   always_comb begin
      nb_row    = cur_row;
      nb_col    = cur_col;
      nb_inside = 1'b0;
      unique case (top_dir_ff)
         DIR_DOWN: begin
            nb_row    = cur_row + coord_type'(1);
            nb_inside = (cur_row != EDGE_LAST);
         end
         DIR_RIGHT: begin
            nb_col    = cur_col + coord_type'(1);
            nb_inside = (cur_col != EDGE_LAST);
         end
         DIR_UP: begin
            nb_row    = cur_row - coord_type'(1);
            nb_inside = (cur_row != '0);
         end
         DIR_LEFT: begin
            nb_col    = cur_col - coord_type'(1);
            nb_inside = (cur_col != '0);
         end
         default: begin
            nb_inside = 1'b0;
         end
      endcase
   end

   assign nb_cell = cell_of(nb_row, nb_col);
   assign nb_goal = nb_inside && (nb_row == goal_row_ff) && (nb_col == goal_col_ff);
   assign nb_open = nb_inside && !blocked[nb_cell] && !depth_ff[DEPTH_W-1];

   always_comb begin
      state_in      = state_ff;
      start_row_in  = start_row_ff;
      start_col_in  = start_col_ff;
      on_path_in    = on_path_ff;
      dead_in       = dead_ff;
      depth_in      = depth_ff;
      top_cell_in   = top_cell_ff;
      top_dir_in    = top_dir_ff;
      found_in      = found_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_path_in   = rsp_path_ff;
      rsp_length_in = rsp_length_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               start_row_in = req_ch.start_row;
               start_col_in = req_ch.start_col;
               on_path_in   = '0;
               dead_in      = '0;
               depth_in     = '0;
               found_in     = 1'b0;
               state_in     = ST_START;
            end
         end
         ST_START: begin
            if (start_row_ff == goal_row_ff && start_col_ff == goal_col_ff) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else if (wall_map_ff[start_cell]) begin
               state_in = ST_DONE;
            end else begin
               top_cell_in             = start_cell;
               top_dir_in              = DIR_DOWN;
               depth_in                = depth_type'(1);
               on_path_in[start_cell]  = 1'b1;
               state_in                = ST_STEP;
            end
         end
         ST_STEP: begin
            if (top_dir_ff == DIR_SPENT) begin
               on_path_in[top_cell_ff] = 1'b0;
               dead_in[top_cell_ff]    = 1'b1;
               depth_in                = depth_ff - depth_type'(1);
               if (depth_ff == depth_type'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  ram_re   = 1'b1;
                  state_in = ST_POP;
               end
            end else begin
               top_dir_in = top_dir_ff + dir_type'(1);
               if (nb_goal) begin
                  found_in = 1'b1;
                  state_in = ST_DONE;
               end else if (nb_open) begin
                  ram_we              = 1'b1;
                  top_cell_in         = nb_cell;
                  top_dir_in          = DIR_DOWN;
                  depth_in            = depth_ff + depth_type'(1);
                  on_path_in[nb_cell] = 1'b1;
               end
            end
         end
         ST_POP: begin
            top_cell_in = pop_entry.cell_idx;
            top_dir_in  = pop_entry.dir;
            state_in    = ST_STEP;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_path_in   = found_ff ? (on_path_ff | (grid_map_type'(1) << goal_cell)) : '0;
               rsp_length_in = found_ff ? LENGTH_W'(depth_ff) : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_map_ff <= '0;
         goal_row_ff <= GOAL_ROW_RESET;
         goal_col_ff <= GOAL_COL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WALL_MAP: wall_map_ff <= csr_wdata;
            CSR_GOAL_ROW: goal_row_ff <= csr_wdata[COORD_W-1:0];
            CSR_GOAL_COL: goal_col_ff <= csr_wdata[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      start_row_ff  <= start_row_in;
      start_col_ff  <= start_col_in;
      on_path_ff    <= on_path_in;
      dead_ff       <= dead_in;
      top_cell_ff   <= top_cell_in;
      top_dir_ff    <= top_dir_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_path_ff   <= rsp_path_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.path_map    = rsp_path_ff;
   assign rsp_ch.path_length = rsp_length_ff;

`ifndef SYNTHESIS
   // The stack is never empty while the sequencer expands or pops.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP || state_ff == ST_POP) |-> depth_ff != '0)
      else $error("stack empty during search step");

   // A cell is never both on the path and marked as a dead end.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP || state_ff == ST_POP || state_ff == ST_DONE)
         |-> (on_path_ff & dead_ff) == '0)
      else $error("cell both on path and dead");

   // A found path holds one more cell than its length, the goal.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff)
         |-> $countones(rsp_path_ff) == int'(rsp_length_ff) + 1)
      else $error("path length does not match path map");

   // A failed search reports an empty path.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_path_ff == '0 && rsp_length_ff == '0))
      else $error("failed search with non-empty path");

   // An accepted start word always begins a search in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> state_ff == ST_START)
      else $error("accepted start word did not begin a search");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the maze search block: drives start words, checks result words.
module testbench;
   import gmdfs_pkg::*;

   typedef struct packed {
      coord_type row;
      coord_type col;
   } start_word_type;

   typedef struct packed {
      logic                found;
      grid_map_type        path_map;
      logic [LENGTH_W-1:0] path_length;
   } path_word_type;

   typedef enum int {PROBE_REFUSED, PROBE_GOAL, PROBE_ENTER} probe_outcome_type;

   localparam int DIR_DOWN    = 0;
   localparam int DIR_RIGHT   = 1;
   localparam int DIR_UP      = 2;
   localparam int DIR_LEFT    = 3;
   localparam int DIR_SPENT   = 4;
   localparam int PHASES      = 10;
   localparam int PHASE_WORDS = 120;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   gmdfs_req_if req_ch();
   gmdfs_rsp_if rsp_ch();

   grid_maze_dfs_path_search_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   grid_map_type   maze_walls = '0;
   coord_type      target_row = GOAL_ROW_RESET;
   coord_type      target_col = GOAL_COL_RESET;
   start_word_type pending_starts[$];
   path_word_type  expected_paths[$];
   int             idle_pct = 33;
   int             mismatch_count = 0;
   bit             req_taken = 1'b0;

   function automatic probe_outcome_type probe_cell(int r, int c, grid_map_type blocked,
                                                    int depth);
      if (r < 0 || c < 0 || r >= GRID_SIDE || c >= GRID_SIDE)
         return PROBE_REFUSED;
      if (r == int'(target_row) && c == int'(target_col))
         return PROBE_GOAL;
      if (blocked[r * GRID_SIDE + c] || depth >= CELLS)
         return PROBE_REFUSED;
      return PROBE_ENTER;
   endfunction

   // Backtracking search with an explicit stack; dead ends are remembered so
   // that they are not entered again within the same search.
   function automatic path_word_type search_path(coord_type sr, coord_type sc);
      grid_map_type      trail = '0;
      grid_map_type      dead = '0;
      int                stack_cell[CELLS];
      int                stack_dir[CELLS];
      int                depth = 0;
      int                r = int'(sr);
      int                c = int'(sc);
      int                cell_idx = 0;
      int                d = 0;
      bit                hit;
      probe_outcome_type outcome;
      path_word_type     word;
      outcome = probe_cell(r, c, maze_walls | trail | dead, depth);
      hit = (outcome == PROBE_GOAL);
      if (outcome == PROBE_ENTER) begin
         cell_idx = r * GRID_SIDE + c;
         trail[cell_idx] = 1'b1;
         stack_cell[0] = cell_idx;
         stack_dir[0] = DIR_DOWN;
         depth = 1;
      end
      while (!hit && depth > 0) begin
         cell_idx = stack_cell[depth - 1];
         d = stack_dir[depth - 1];
         if (d == DIR_SPENT) begin
            trail[cell_idx] = 1'b0;
            dead[cell_idx] = 1'b1;
            depth--;
         end else begin
            stack_dir[depth - 1] = d + 1;
            r = cell_idx / GRID_SIDE;
            c = cell_idx % GRID_SIDE;
            case (d)
               DIR_DOWN:  r++;
               DIR_RIGHT: c++;
               DIR_UP:    r--;
               DIR_LEFT:  c--;
               default:   ;
            endcase
            outcome = probe_cell(r, c, maze_walls | trail | dead, depth);
            if (outcome == PROBE_GOAL) begin
               hit = 1'b1;
            end else if (outcome == PROBE_ENTER) begin
               cell_idx = r * GRID_SIDE + c;
               trail[cell_idx] = 1'b1;
               stack_cell[depth] = cell_idx;
               stack_dir[depth] = DIR_DOWN;
               depth++;
            end
         end
      end
      word = '0;
      if (hit) begin
         word.found = 1'b1;
         word.path_map = trail;
         word.path_map[int'(target_row) * GRID_SIDE + int'(target_col)] = 1'b1;
         word.path_length = LENGTH_W'($countones(trail));
      end
      return word;
   endfunction

   task automatic set_maze(grid_map_type walls, coord_type goal_r, coord_type goal_c);
      while (pending_starts.size() != 0 || expected_paths.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_WALL_MAP;
      csr_wdata <= walls;
      @(negedge clock);
      csr_index <= CSR_GOAL_ROW;
      csr_wdata <= CSR_W'(goal_r);
      @(negedge clock);
      csr_index <= CSR_GOAL_COL;
      csr_wdata <= CSR_W'(goal_c);
      @(negedge clock);
      csr_we <= 1'b0;
      maze_walls = walls;
      target_row = goal_r;
      target_col = goal_c;
      @(posedge clock);
   endtask

   task automatic queue_start(coord_type r, coord_type c);
      start_word_type word;
      word.row = r;
      word.col = c;
      pending_starts.push_back(word);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("grid_maze_dfs_path_search_top verification failed");
      $finish;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (!req_ch.valid || req_taken) begin
            req_taken = 1'b0;
            if (pending_starts.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.start_row <= pending_starts[0].row;
               req_ch.start_col <= pending_starts[0].col;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      path_word_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            expected_paths.push_back(search_path(req_ch.start_row, req_ch.start_col));
            if (pending_starts.size() != 0)
               pending_starts.pop_front();
            req_taken = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_paths.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result word: found %0b path_map %h path_length %0d",
                        $time, rsp_ch.found, rsp_ch.path_map, rsp_ch.path_length);
            end else begin
               want = expected_paths.pop_front();
               if (rsp_ch.found !== want.found) begin
                  mismatch_count++;
                  $display("%0t: found mismatch: expected %0b actual %0b",
                           $time, want.found, rsp_ch.found);
               end
               if (rsp_ch.path_map !== want.path_map) begin
                  mismatch_count++;
                  $display("%0t: path_map mismatch: expected %h actual %h",
                           $time, want.path_map, rsp_ch.path_map);
               end
               if (rsp_ch.path_length !== want.path_length) begin
                  mismatch_count++;
                  $display("%0t: path_length mismatch: expected %0d actual %0d",
                           $time, want.path_length, rsp_ch.path_length);
               end
            end
         end
      end
   end

   initial begin
      grid_map_type walls;
      coord_type    gr;
      coord_type    gc;
      coord_type    sr;
      coord_type    sc;
      int           density;
      int           pick;
      int           tries;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.start_row = '0;
      req_ch.start_col = '0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_WALL_MAP;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // The reset setting is an open grid with the goal at row 5, column 3.
      queue_start(GOAL_ROW_RESET, GOAL_COL_RESET);
      queue_start(3'd0, 3'd0);
      queue_start(3'd7, 3'd7);
      queue_start(3'd0, 3'd7);
      queue_start(3'd7, 3'd0);
      queue_start(3'd5, 3'd2);

      // A grid of walls only: only a start on the goal itself succeeds.
      set_maze('1, 3'd0, 3'd0);
      queue_start(3'd0, 3'd0);
      queue_start(3'd0, 3'd1);
      queue_start(3'd7, 3'd7);

      // Two open cells next to walled goals; the goal is entered despite its wall.
      walls = '1;
      walls[1] = 1'b0;
      walls[62] = 1'b0;
      set_maze(walls, 3'd0, 3'd0);
      queue_start(3'd0, 3'd1);
      queue_start(3'd7, 3'd6);
      set_maze(walls, 3'd7, 3'd7);
      queue_start(3'd7, 3'd6);
      queue_start(3'd0, 3'd1);

      for (int p = 0; p < PHASES; p++) begin
         density = 15 + 10 * (p % 4);
         for (int k = 0; k < CELLS; k++)
            walls[k] = ($urandom_range(99) < density);
         gr = coord_type'($urandom_range(7));
         gc = coord_type'($urandom_range(7));
         case (p)
            0: begin
               walls = '0;
               gr = 3'd0;
               gc = 3'd0;
            end
            1: begin
               walls = '1;
               gr = 3'd7;
               gc = 3'd7;
            end
            2: walls = '0;
            7: walls[int'(gr) * GRID_SIDE + int'(gc)] = 1'b1;
            default: ;
         endcase
         set_maze(walls, gr, gc);
         idle_pct = (p == 5) ? 0 : 33;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            pick = $urandom_range(99);
            sr = coord_type'($urandom_range(7));
            sc = coord_type'($urandom_range(7));
            if (pick < 6) begin
               sr = gr;
               sc = gc;
            end else if (pick < 80) begin
               for (tries = 0; tries < 16 && walls[int'(sr) * GRID_SIDE + int'(sc)]; tries++) begin
                  sr = coord_type'($urandom_range(7));
                  sc = coord_type'($urandom_range(7));
               end
            end
            queue_start(sr, sc);
         end
      end

      while (pending_starts.size() != 0 || expected_paths.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("grid_maze_dfs_path_search_top verification clean");
      else
         $display("grid_maze_dfs_path_search_top verification failed");
      $finish;
   end

endmodule
